/* hw/rtl/assert_macros.svh */
// Assertion helpers. Both sample on clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// Whenever the trigger holds, the condition holds in the same cycle.
`define ASSERT_IMPL(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error("assertion failed");

`endif

/* hw/rtl/ffca_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ffca_pkg;

  localparam int unsigned FREE_SLOTS_DEF = 64;
  localparam int unsigned PAGE_BYTES_DEF = 4096;
  localparam int unsigned HDR_BYTES      = 8;
  localparam int unsigned SPLIT_MIN      = 16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EXH  = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_BIG,
    CMD_RD_IDX,
    CMD_NEXT,
    CMD_FIT_TAKE,
    CMD_FRESH1,
    CMD_SPLIT,
    CMD_RM_RD,
    CMD_RM_WR,
    CMD_RM_END,
    CMD_MERGE,
    CMD_FULL,
    CMD_SH_INIT,
    CMD_SH_RD,
    CMD_SH_WR
  } cmd_e;

  // The final write of an insert has its own strobe so the enum stays four bits.
  typedef struct packed {
    cmd_e cmd;
    logic put;
  } dp_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic is_small;
    logic idx_end;
    logic fit_hit;
    logic m_below;
    logic m_above;
    logic a_lt;
    logic full;
    logic rm_more;
    logic sh_more;
    logic split;
    logic fresh_ok;
  } dp_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/first_fit_coalescing_allocator_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// First-fit heap allocator with an address-sorted free table that coalesces
// neighbors on free. A request is taken when start is high and busy is low;
// exactly one result appears later for one cycle with done_o high, and the
// receiver cannot stall it, so it must capture the result in that cycle. The
// free table lives in a single-port-read RAM, so each request walks it one
// entry at a time: a small allocation scans for the first fit and removes
// that entry by shifting the tail down, or maps a fresh page when none fits,
// then may insert a split remainder; a small free scans for neighbors,
// removing each merged entry and rescanning from the start, and finally
// shifts the tail up to open a slot unless the table is full. A large
// request does not walk the table. A block merges with more than its two
// direct neighbors only when the table holds overlapping blocks. heap_base
// must be written only while the block is idle. The counters and the entry
// count are reported with every result.
module first_fit_coalescing_allocator_top import ffca_pkg::*; #(
  parameter int unsigned FREE_SLOTS = FREE_SLOTS_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  output logic             done_o,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        operation_i,
  input  wire logic [23:0] request_size_i,
  input  wire logic [31:0] payload_address_i,
  input  wire logic [24:0] header_size_i,
  output logic [1:0]       status_o,
  output logic [31:0]      result_address_o,
  output logic [24:0]      block_size_o,
  output logic [31:0]      pages_mapped_o,
  output logic [31:0]      pages_unmapped_o,
  output logic [31:0]      allocs_done_o,
  output logic [31:0]      frees_done_o,
  output logic [6:0]       free_entries_used_o
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller sequences scans and shifts; the datapath holds the table, counters and request.
  ffca_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .done_o(done_o),
    .stat_i(stat),
    .cmd_o (cmd)
  );

  ffca_dp #(.FREE_SLOTS(FREE_SLOTS), .PAGE_BYTES(PAGE_BYTES)) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .operation_i        (operation_i),
    .request_size_i     (request_size_i),
    .payload_address_i  (payload_address_i),
    .header_size_i      (header_size_i),
    .status_o           (status_o),
    .result_address_o   (result_address_o),
    .block_size_o       (block_size_o),
    .pages_mapped_o     (pages_mapped_o),
    .pages_unmapped_o   (pages_unmapped_o),
    .allocs_done_o      (allocs_done_o),
    .frees_done_o       (frees_done_o),
    .free_entries_used_o(free_entries_used_o)
  );
endmodule
`default_nettype wire

/* hw/rtl/ffca_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module ffca_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/ffca_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ffca_dp import ffca_pkg::*; #(
  parameter int unsigned FREE_SLOTS = FREE_SLOTS_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  output dp_stat_t         stat_o,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        operation_i,
  input  wire logic [23:0] request_size_i,
  input  wire logic [31:0] payload_address_i,
  input  wire logic [24:0] header_size_i,
  output logic [1:0]       status_o,
  output logic [31:0]      result_address_o,
  output logic [24:0]      block_size_o,
  output logic [31:0]      pages_mapped_o,
  output logic [31:0]      pages_unmapped_o,
  output logic [31:0]      allocs_done_o,
  output logic [31:0]      frees_done_o,
  output logic [6:0]       free_entries_used_o
);
  localparam int unsigned IW  = $clog2(FREE_SLOTS + 1);
  localparam int unsigned AW  = $clog2(FREE_SLOTS);
  localparam int unsigned LOG = $clog2(PAGE_BYTES);

  logic [31:0] hb_q, nfp_q, nfp_d, mapped_q, mapped_d, unmapped_q, unmapped_d;
  logic [31:0] allocs_q, allocs_d, frees_q, frees_d;
  logic [IW-1:0] used_q, used_d, idx_q, idx_d, k_q, k_d;
  logic [1:0]  st_q, st_d;
  logic [31:0] raddr_res_q, raddr_res_d, a_q, a_d, s_q, s_d, base_q, base_d, blen_q, blen_d;
  logic [24:0] rsize_q, rsize_d, size_q, size_d, hsz_q, hsz_d;
  logic        op_q, op_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [63:0]   ram_wd, ram_rd;
  logic [31:0]   cs, cl, diff;
  logic [32:0]   c_end, a_end, ms;
  logic [31:0]   ms_sat;
  logic [25:0]   pages_big;
  logic [33:0]   fresh_start, bytes1, bytes_big;

  ffca_ram #(.WIDTH(64), .DEPTH(FREE_SLOTS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_wa),
    .wdata_i(ram_wd),
    .re_i   (ram_re),
    .raddr_i(ram_ra),
    .rdata_o(ram_rd)
  );

  assign cs     = ram_rd[63:32];
  assign cl     = ram_rd[31:0];
  assign c_end  = {1'b0, cs} + {1'b0, cl};
  assign a_end  = {1'b0, a_q} + {1'b0, s_q};
  assign ms     = {1'b0, s_q} + {1'b0, cl};
  assign ms_sat = ms[32] ? 32'hFFFF_FFFF : ms[31:0];
  assign diff   = blen_q - {7'd0, size_q};

  assign fresh_start = {2'b00, hb_q} + {2'b00, nfp_q};
  assign bytes1      = 34'(PAGE_BYTES);
  assign pages_big   = ({1'b0, size_q} + 26'(PAGE_BYTES - 1)) >> LOG;
  assign bytes_big   = 34'(pages_big) << LOG;

  always_comb begin
    stat_o.is_alloc = (op_q == OP_ALLOC);
    stat_o.is_small = (op_q == OP_ALLOC) ? (size_q < 25'(PAGE_BYTES))
                                         : (hsz_q < 25'(PAGE_BYTES));
    stat_o.idx_end  = (idx_q == used_q);
    stat_o.fit_hit  = (cl >= {7'd0, size_q});
    stat_o.m_below  = (c_end == {1'b0, a_q});
    stat_o.m_above  = (a_end == {1'b0, cs});
    stat_o.a_lt     = (a_q < cs);
    stat_o.full     = (used_q >= IW'(FREE_SLOTS));
    stat_o.rm_more  = (({1'b0, idx_q} + 1'b1) < {1'b0, used_q});
    stat_o.sh_more  = (k_q > idx_q);
    stat_o.split    = (diff > 32'(SPLIT_MIN));
    stat_o.fresh_ok = ((fresh_start + bytes1) <= 34'h1_0000_0000);
  end

  always_comb begin
    ram_we = 1'b0;
    ram_wa = idx_q[AW-1:0];
    ram_wd = ram_rd;
    ram_re = 1'b0;
    ram_ra = idx_q[AW-1:0];
    unique case (cmd_i.cmd)
      CMD_RD_IDX: ram_re = 1'b1;
      CMD_RM_RD: begin
        ram_re = 1'b1;
        ram_ra = AW'(idx_q + 1'b1);
      end
      CMD_RM_WR: ram_we = 1'b1;
      CMD_SH_RD: begin
        ram_re = 1'b1;
        ram_ra = AW'(k_q - 1'b1);
      end
      CMD_SH_WR: begin
        ram_we = 1'b1;
        ram_wa = k_q[AW-1:0];
      end
      default: ;
    endcase
    if (cmd_i.put) begin
      ram_we = 1'b1;
      ram_wa = idx_q[AW-1:0];
      ram_wd = {a_q, s_q};
    end
  end

  always_comb begin
    nfp_d = nfp_q; mapped_d = mapped_q; unmapped_d = unmapped_q;
    allocs_d = allocs_q; frees_d = frees_q; used_d = used_q;
    idx_d = idx_q; k_d = k_q; st_d = st_q; raddr_res_d = raddr_res_q;
    rsize_d = rsize_q; a_d = a_q; s_d = s_q; base_d = base_q; blen_d = blen_q;
    size_d = size_q; hsz_d = hsz_q; op_d = op_q;
    unique case (cmd_i.cmd)
      CMD_LOAD: begin
        op_d        = operation_i;
        size_d      = {1'b0, request_size_i} + 25'(HDR_BYTES);
        hsz_d       = header_size_i;
        a_d         = payload_address_i - 32'(HDR_BYTES);
        s_d         = {7'd0, header_size_i};
        idx_d       = '0;
        st_d        = ST_OK;
        raddr_res_d = '0;
        rsize_d     = '0;
        if (operation_i == OP_ALLOC) begin
          allocs_d = allocs_q + 1'b1;
        end else begin
          frees_d = frees_q + 1'b1;
        end
      end
      CMD_BIG: begin
        if (op_q == OP_FREE) begin
          unmapped_d = unmapped_q + 32'(hsz_q >> LOG);
        end else if ((fresh_start + bytes_big) <= 34'h1_0000_0000) begin
          raddr_res_d = fresh_start[31:0] + 32'(HDR_BYTES);
          rsize_d     = bytes_big[24:0];
          nfp_d       = nfp_q + bytes_big[31:0];
          mapped_d    = mapped_q + 32'(pages_big);
        end else begin
          st_d = ST_EXH;
        end
      end
      CMD_NEXT: idx_d = idx_q + 1'b1;
      CMD_FIT_TAKE: begin
        base_d = cs;
        blen_d = cl;
      end
      CMD_FRESH1: begin
        if (stat_o.fresh_ok) begin
          base_d   = fresh_start[31:0];
          blen_d   = 32'(PAGE_BYTES);
          nfp_d    = nfp_q + bytes1[31:0];
          mapped_d = mapped_q + 1'b1;
        end else begin
          st_d = ST_EXH;
        end
      end
      CMD_SPLIT: begin
        idx_d       = '0;
        raddr_res_d = base_q + 32'(HDR_BYTES);
        if (stat_o.split) begin
          a_d     = base_q + {7'd0, size_q};
          s_d     = diff;
          rsize_d = size_q;
        end else begin
          rsize_d = blen_q[24:0];
        end
      end
      CMD_RM_WR: idx_d = idx_q + 1'b1;
      CMD_RM_END: begin
        used_d = used_q - 1'b1;
        idx_d  = '0;
      end
      CMD_MERGE: begin
        if (stat_o.m_below) begin
          a_d = cs;
        end
        s_d = ms_sat;
      end
      CMD_FULL: st_d = ST_FULL;
      CMD_SH_INIT: k_d = used_q;
      CMD_SH_WR: k_d = k_q - 1'b1;
      default: ;
    endcase
    if (cmd_i.put) begin
      used_d = used_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_q       <= '0;
      nfp_q      <= '0;
      mapped_q   <= '0;
      unmapped_q <= '0;
      allocs_q   <= '0;
      frees_q    <= '0;
      used_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        hb_q <= cfg_wdata_i;
      end
      nfp_q      <= nfp_d;
      mapped_q   <= mapped_d;
      unmapped_q <= unmapped_d;
      allocs_q   <= allocs_d;
      frees_q    <= frees_d;
      used_q     <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    k_q         <= k_d;
    st_q        <= st_d;
    raddr_res_q <= raddr_res_d;
    rsize_q     <= rsize_d;
    a_q         <= a_d;
    s_q         <= s_d;
    base_q      <= base_d;
    blen_q      <= blen_d;
    size_q      <= size_d;
    hsz_q       <= hsz_d;
    op_q        <= op_d;
  end

  assign status_o            = st_q;
  assign result_address_o    = raddr_res_q;
  assign block_size_o        = rsize_q;
  assign pages_mapped_o      = mapped_q;
  assign pages_unmapped_o    = unmapped_q;
  assign allocs_done_o       = allocs_q;
  assign frees_done_o        = frees_q;
  assign free_entries_used_o = 7'(used_q);

  `ASSERT_ALWAYS(a_used_bound, used_q <= IW'(FREE_SLOTS))
  `ASSERT_IMPL(a_put_room, cmd_i.put, used_q < IW'(FREE_SLOTS))
  `ASSERT_IMPL(a_rm_nonempty, cmd_i.cmd == CMD_RM_END, used_q != '0)
endmodule
`default_nettype wire

/* hw/rtl/ffca_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module ffca_ctrl import ffca_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  output logic          done_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_FIT_RD  = 4'd2;
  localparam logic [3:0] S_FIT_CHK = 4'd3;
  localparam logic [3:0] S_FRESH   = 4'd4;
  localparam logic [3:0] S_RM_RD   = 4'd5;
  localparam logic [3:0] S_RM_WR   = 4'd6;
  localparam logic [3:0] S_SPLIT   = 4'd7;
  localparam logic [3:0] S_INS_RD  = 4'd8;
  localparam logic [3:0] S_INS_CHK = 4'd9;
  localparam logic [3:0] S_INS_END = 4'd10;
  localparam logic [3:0] S_SH_RD   = 4'd11;
  localparam logic [3:0] S_SH_WR   = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  logic [3:0] state_q, state_d;
  logic       ins_q, ins_d;  // a removal belongs to an insert rather than a fit

  always_comb begin
    state_d   = state_q;
    ins_d     = ins_q;
    cmd_o.cmd = CMD_NONE;
    cmd_o.put = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.cmd = CMD_LOAD;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        ins_d = !stat_i.is_alloc;
        if (!stat_i.is_small) begin
          cmd_o.cmd = CMD_BIG;
          state_d   = S_DONE;
        end else if (stat_i.is_alloc) begin
          state_d = S_FIT_RD;
        end else begin
          state_d = S_INS_RD;
        end
      end
      S_FIT_RD: begin
        if (stat_i.idx_end) begin
          state_d = S_FRESH;
        end else begin
          cmd_o.cmd = CMD_RD_IDX;
          state_d   = S_FIT_CHK;
        end
      end
      S_FIT_CHK: begin
        if (stat_i.fit_hit) begin
          cmd_o.cmd = CMD_FIT_TAKE;
          state_d   = S_RM_RD;
        end else begin
          cmd_o.cmd = CMD_NEXT;
          state_d   = S_FIT_RD;
        end
      end
      S_FRESH: begin
        cmd_o.cmd = CMD_FRESH1;
        state_d   = stat_i.fresh_ok ? S_SPLIT : S_DONE;
      end
      S_RM_RD: begin
        if (stat_i.rm_more) begin
          cmd_o.cmd = CMD_RM_RD;
          state_d   = S_RM_WR;
        end else begin
          cmd_o.cmd = CMD_RM_END;
          state_d   = ins_q ? S_INS_RD : S_SPLIT;
        end
      end
      S_RM_WR: begin
        cmd_o.cmd = CMD_RM_WR;
        state_d   = S_RM_RD;
      end
      S_SPLIT: begin
        cmd_o.cmd = CMD_SPLIT;
        ins_d     = 1'b1;
        state_d   = stat_i.split ? S_INS_RD : S_DONE;
      end
      S_INS_RD: begin
        if (stat_i.idx_end) begin
          state_d = S_INS_END;
        end else begin
          cmd_o.cmd = CMD_RD_IDX;
          state_d   = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (stat_i.m_below || stat_i.m_above) begin
          cmd_o.cmd = CMD_MERGE;
          state_d   = S_RM_RD;
        end else if (stat_i.a_lt) begin
          state_d = S_INS_END;
        end else begin
          cmd_o.cmd = CMD_NEXT;
          state_d   = S_INS_RD;
        end
      end
      S_INS_END: begin
        if (stat_i.full) begin
          cmd_o.cmd = CMD_FULL;
          state_d   = S_DONE;
        end else begin
          cmd_o.cmd = CMD_SH_INIT;
          state_d   = S_SH_RD;
        end
      end
      S_SH_RD: begin
        if (stat_i.sh_more) begin
          cmd_o.cmd = CMD_SH_RD;
          state_d   = S_SH_WR;
        end else begin
          cmd_o.put = 1'b1;
          state_d   = S_DONE;
        end
      end
      S_SH_WR: begin
        cmd_o.cmd = CMD_SH_WR;
        state_d   = S_SH_RD;
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ins_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ins_q   <= ins_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
endmodule
`default_nettype wire
